// ----- src/lrf_pkg.sv -----
// shared types, constants and helpers for the linear regression fit block
package lrf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MIN_POINTS = 3;
  localparam int CNT_W      = $clog2(MAX_POINTS) + 1;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int SX_W       = 26;
  localparam int SXX_W      = 42;
  localparam int SE_W       = 43;
  localparam int SEX_W      = 59;
  localparam int MUL_W      = 64;
  localparam int MUL_CNT_W  = $clog2(MUL_W);
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIV_W      = 80;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int DEN_W      = 64;
  localparam int PX_W       = 48;

  localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;

  localparam logic [2:0] REG_FIT_MODE     = 3'd0;
  localparam logic [2:0] REG_STEP_RATE    = 3'd1;
  localparam logic [2:0] REG_PASS_COUNT   = 3'd2;
  localparam logic [2:0] REG_START_WEIGHT = 3'd3;
  localparam logic [2:0] REG_START_BIAS   = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PREDICT = 1'b1;
  localparam logic KIND_FIT   = 1'b0;
  localparam logic KIND_PRED  = 1'b1;
  localparam logic MODE_CLOSED = 1'b0;

  localparam logic [1:0] FS_OK      = 2'd0;
  localparam logic [1:0] FS_FEW     = 2'd1;
  localparam logic [1:0] FS_DEGEN   = 2'd2;
  localparam logic [1:0] FS_DROPPED = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] predicted;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [5:0] {
    DP_NOP, DP_ACCEPT, DP_PREDICT, DP_PUSH, DP_FIT_BEGIN, DP_FEW, DP_DEGEN, DP_FIN,
    DP_MUL_NSXX, DP_MUL_SXSX, DP_MUL_NSXY, DP_MUL_SXSY, DP_MUL_SXXSY, DP_MUL_SXSXY,
    DP_MUL_RSE, DP_MUL_RSEX,
    DP_DIV_W, DP_DIV_B, DP_DIV_SE, DP_DIV_SEX,
    DP_DEN_SET, DP_DEN_SUB, DP_NUM_SET, DP_NUM_SUB,
    DP_W_FROM_Q, DP_B_FROM_Q, DP_SE_FROM_Q, DP_SEX_FROM_Q, DP_GB_UPD, DP_GW_UPD,
    DP_GD_INIT, DP_PASS_BEGIN, DP_PT_MUL1, DP_PT_ERR, DP_PT_MUL2, DP_PT_ACC, DP_GD_END
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_PRED, ST_FIT, ST_FIN, ST_OUT,
    ST_DEN0, ST_DEN0W, ST_DEN1, ST_DEN1W, ST_DENCHK,
    ST_NW0, ST_NW0W, ST_NW1, ST_NW1W, ST_DW, ST_DWW,
    ST_NB0, ST_NB0W, ST_NB1, ST_NB1W, ST_DB, ST_DBW,
    ST_GD_INIT, ST_PASS, ST_PT_RD, ST_PT_M1, ST_PT_ERR, ST_PT_M2, ST_PT_ACC,
    ST_DSE, ST_DSEW, ST_DSX, ST_DSXW, ST_MB, ST_MBW, ST_MW, ST_MWW, ST_GD_END
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt3;
    logic mode;
    logic den_bad;
    logic pass_zero;
    logic idx_last;
    logic pass_last;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > PROD_W'(SAT_HI)) r = SAT_HI;
    else if (v < PROD_W'(SAT_LO)) r = SAT_LO;
    else r = 32'(v);
    return r;
  endfunction

endpackage

// ----- src/lrf_mul.sv -----
// shift-and-add signed multiplier, one bit per cycle
module lrf_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [lrf_pkg::MUL_W-1:0]   a,
  input  logic signed [lrf_pkg::MUL_W-1:0]   b,
  output logic                               done,
  output logic signed [lrf_pkg::PROD_W-1:0]  prod
);
  import lrf_pkg::*;

  logic [MUL_W-1:0]     a_mag, a_abs, b_abs;
  logic [PROD_W-1:0]    p;
  logic [MUL_W:0]       hi_sum;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy, fix, neg;

  assign a_abs  = a[MUL_W-1] ? MUL_W'(~a + 1'b1) : MUL_W'(a);
  assign b_abs  = b[MUL_W-1] ? MUL_W'(~b + 1'b1) : MUL_W'(b);
  assign hi_sum = {1'b0, p[PROD_W-1:MUL_W]} + (p[0] ? {1'b0, a_mag} : '0);
  assign prod   = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == MUL_CNT_W'(MUL_W - 1)) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end
    end else if (fix) begin
      fix  <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a_abs;
      p     <= {{MUL_W{1'b0}}, b_abs};
      neg   <= a[MUL_W-1] ^ b[MUL_W-1];
    end else if (busy) begin
      p <= {hi_sum, p[MUL_W-1:1]};
    end else if (fix && neg) begin
      p <= ~p + 1'b1;
    end
  end

endmodule

// ----- src/lrf_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module lrf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lrf_pkg::DIV_W-1:0]       dividend,
  input  logic [lrf_pkg::DEN_W-1:0]       divisor,
  output logic                            done,
  output logic [lrf_pkg::DIV_W-1:0]       quot
);
  import lrf_pkg::*;

  logic [DIV_W-1:0]     q;
  logic [DEN_W-1:0]     rem, dsr;
  logic [DEN_W:0]       trial, diff;
  logic                 ge;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  assign trial = {rem, q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      q   <= {q[DIV_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

// ----- src/lrf_dp.sv -----
// datapath: point store, running sums, fit arithmetic, config and result registers
module lrf_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lrf_pkg::dp_cmd_t     cmd,
  input  lrf_pkg::in_item_t    in_data,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lrf_pkg::out_item_t   out_data,
  output lrf_pkg::dp_stat_t    stat
);
  import lrf_pkg::*;

  localparam logic [DIV_W-1:0] Q_POS_LIM = DIV_W'(32'h7FFF_FFFF);
  localparam logic [DIV_W-1:0] Q_NEG_LIM = DIV_W'(32'h8000_0000);

  // configuration
  logic               fit_mode;
  logic [15:0]        step_rate, pass_count;
  logic signed [31:0] start_weight, start_bias;

  // accumulation state
  logic [CNT_W-1:0]        n;
  logic signed [SX_W-1:0]  sx, sy;
  logic signed [SXX_W-1:0] sxx, sxy;
  logic                    ovf;
  logic signed [31:0]      fw, fb;

  // fit working registers
  logic signed [31:0]       gw, gb, err;
  logic [IDX_W-1:0]         idx;
  logic [15:0]              pass;
  logic signed [PX_W-1:0]   px, ex;
  logic signed [SE_W-1:0]   se, se_q;
  logic signed [SEX_W-1:0]  sex, sex_q;
  logic signed [PROD_W-1:0] den, num;
  logic                     div_neg;
  logic [1:0]               fst;
  out_item_t                pend;

  logic signed [15:0] x_mem [MAX_POINTS];
  logic signed [15:0] y_mem [MAX_POINTS];
  logic signed [15:0] xr, yr;

  logic                     full, load_ok;
  logic signed [31:0]       xx, xy;
  logic [PROD_W-1:0]        num_abs;
  logic [SE_W-1:0]          se_abs;
  logic [SEX_W-1:0]         sex_abs;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     mul_start, mul_done;
  logic signed [PROD_W-1:0] prod;
  logic [DIV_W-1:0]         div_dvd, quot;
  logic [DEN_W-1:0]         div_dsr;
  logic                     div_start, div_done, div_sign;

  function automatic logic signed [31:0] q_sat(input logic [DIV_W-1:0] q, input logic ng);
    logic signed [31:0] r;
    if (ng) r = (q > Q_NEG_LIM) ? SAT_LO : 32'(~q + 1'b1);
    else    r = (q > Q_POS_LIM) ? SAT_HI : 32'(q);
    return r;
  endfunction

  assign full    = (n == CNT_W'(MAX_POINTS));
  assign load_ok = (cmd.op == DP_ACCEPT) && (in_data.operation == OP_LOAD) && !full;
  assign xx      = 32'(in_data.x_value) * 32'(in_data.x_value);
  assign xy      = 32'(in_data.x_value) * 32'(in_data.y_value);
  assign num_abs = num[PROD_W-1] ? PROD_W'(~num + 1'b1) : PROD_W'(num);
  assign se_abs  = se[SE_W-1] ? SE_W'(~se + 1'b1) : SE_W'(se);
  assign sex_abs = sex[SEX_W-1] ? SEX_W'(~sex + 1'b1) : SEX_W'(sex);

  // operand selection for the shared units
  always_comb begin
    mul_start = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (cmd.op)
      DP_MUL_NSXX:  begin mul_a = MUL_W'({1'b0, n}); mul_b = MUL_W'(sxx); end
      DP_MUL_SXSX:  begin mul_a = MUL_W'(sx);        mul_b = MUL_W'(sx);  end
      DP_MUL_NSXY:  begin mul_a = MUL_W'({1'b0, n}); mul_b = MUL_W'(sxy); end
      DP_MUL_SXSY:  begin mul_a = MUL_W'(sx);        mul_b = MUL_W'(sy);  end
      DP_MUL_SXXSY: begin mul_a = MUL_W'(sxx);       mul_b = MUL_W'(sy);  end
      DP_MUL_SXSXY: begin mul_a = MUL_W'(sx);        mul_b = MUL_W'(sxy); end
      DP_MUL_RSE:   begin mul_a = MUL_W'({1'b0, step_rate}); mul_b = MUL_W'(se_q);  end
      DP_MUL_RSEX:  begin mul_a = MUL_W'({1'b0, step_rate}); mul_b = MUL_W'(sex_q); end
      default:      mul_start = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dsr   = den[DEN_W-1:0];
    div_sign  = 1'b0;
    unique case (cmd.op)
      DP_DIV_W: begin
        div_dvd  = DIV_W'(num_abs << 16);
        div_sign = num[PROD_W-1];
      end
      DP_DIV_B: begin
        div_dvd  = DIV_W'(num_abs << 8);
        div_sign = num[PROD_W-1];
      end
      DP_DIV_SE: begin
        div_dvd  = DIV_W'(se_abs);
        div_dsr  = DEN_W'(n);
        div_sign = se[SE_W-1];
      end
      DP_DIV_SEX: begin
        div_dvd  = DIV_W'(sex_abs);
        div_dsr  = DEN_W'(n);
        div_sign = sex[SEX_W-1];
      end
      default: div_start = 1'b0;
    endcase
  end

  lrf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  lrf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= MODE_CLOSED;
      step_rate    <= 16'd655;
      pass_count   <= 16'd1000;
      start_weight <= '0;
      start_bias   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIT_MODE:     fit_mode     <= cfg_data[0];
        REG_STEP_RATE:    step_rate    <= cfg_data[15:0];
        REG_PASS_COUNT:   pass_count   <= cfg_data[15:0];
        REG_START_WEIGHT: start_weight <= cfg_data;
        REG_START_BIAS:   start_bias   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      x_mem[n[IDX_W-1:0]] <= in_data.x_value;
      y_mem[n[IDX_W-1:0]] <= in_data.y_value;
    end
    xr <= x_mem[idx];
    yr <= y_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      sx        <= '0;
      sy        <= '0;
      sxx       <= '0;
      sxy       <= '0;
      ovf       <= 1'b0;
      fw        <= '0;
      fb        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == DP_PUSH) begin
        out_data  <= pend;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (div_start) div_neg <= div_sign;
      unique case (cmd.op)
        DP_ACCEPT: begin
          if (in_data.operation == OP_PREDICT) begin
            px <= PX_W'(fw) * PX_W'(in_data.x_value);
          end else if (!full) begin
            n   <= n + 1'b1;
            sx  <= sx + SX_W'(in_data.x_value);
            sy  <= sy + SX_W'(in_data.y_value);
            sxx <= sxx + SXX_W'(xx);
            sxy <= sxy + SXX_W'(xy);
          end else begin
            ovf <= 1'b1;
          end
        end
        DP_PREDICT: begin
          pend.result_kind <= KIND_PRED;
          pend.slope       <= fw;
          pend.intercept   <= fb;
          pend.predicted   <= sat32(PROD_W'(px >>> 8) + PROD_W'(fb));
          pend.status      <= FS_OK;
        end
        DP_FIT_BEGIN: fst <= FS_OK;
        DP_FEW:       fst <= FS_FEW;
        DP_DEGEN: begin
          fw  <= '0;
          fb  <= '0;
          fst <= FS_DEGEN;
        end
        DP_FIN: begin
          pend.result_kind <= KIND_FIT;
          pend.slope       <= fw;
          pend.intercept   <= fb;
          pend.predicted   <= '0;
          pend.status      <= (fst == FS_OK && ovf) ? FS_DROPPED : fst;
          n   <= '0;
          sx  <= '0;
          sy  <= '0;
          sxx <= '0;
          sxy <= '0;
          ovf <= 1'b0;
        end
        DP_DEN_SET:    den <= prod;
        DP_DEN_SUB:    den <= den - prod;
        DP_NUM_SET:    num <= prod;
        DP_NUM_SUB:    num <= num - prod;
        DP_W_FROM_Q:   fw <= q_sat(quot, div_neg);
        DP_B_FROM_Q:   fb <= q_sat(quot, div_neg);
        DP_SE_FROM_Q:  se_q <= SE_W'(div_neg ? (~quot + 1'b1) : quot);
        DP_SEX_FROM_Q: sex_q <= SEX_W'(div_neg ? (~quot + 1'b1) : quot);
        DP_GB_UPD:     gb <= sat32(PROD_W'(gb) - (prod >>> 16));
        DP_GW_UPD: begin
          gw   <= sat32(PROD_W'(gw) - (prod >>> 24));
          pass <= pass + 1'b1;
        end
        DP_GD_INIT: begin
          gw   <= start_weight;
          gb   <= start_bias;
          pass <= '0;
        end
        DP_PASS_BEGIN: begin
          se  <= '0;
          sex <= '0;
          idx <= '0;
        end
        DP_PT_MUL1: px <= PX_W'(gw) * PX_W'(xr);
        // error of one point against the current model
        DP_PT_ERR:  err <= sat32(PROD_W'(px >>> 8) + PROD_W'(gb) - (PROD_W'(yr) <<< 8));
        DP_PT_MUL2: ex <= PX_W'(err) * PX_W'(xr);
        DP_PT_ACC: begin
          se  <= se + SE_W'(err);
          sex <= sex + SEX_W'(ex);
          idx <= idx + 1'b1;
        end
        DP_GD_END: begin
          fw <= gw;
          fb <= gb;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.n_lt3     = (n < CNT_W'(MIN_POINTS));
    stat.mode      = fit_mode;
    stat.den_bad   = den[PROD_W-1] || (den == '0);
    stat.pass_zero = (pass_count == 16'd0);
    stat.idx_last  = ({1'b0, idx} == n - 1'b1);
    stat.pass_last = (pass == pass_count - 16'd1);
    stat.mul_done  = mul_done;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

// ----- src/lrf_ctrl.sv -----
// controller: sequences loading, prediction and both fit methods
module lrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  input  logic               in_last,
  input  lrf_pkg::dp_stat_t  stat,
  output logic               in_stall,
  output lrf_pkg::dp_cmd_t   cmd
);
  import lrf_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_ACCEPT;
          if (in_op == OP_PREDICT) state_next = ST_PRED;
          else if (in_last)        state_next = ST_FIT;
        end
      end
      ST_PRED: begin
        cmd.op     = DP_PREDICT;
        state_next = ST_OUT;
      end
      ST_FIT: begin
        if (stat.n_lt3) begin
          cmd.op     = DP_FEW;
          state_next = ST_FIN;
        end else begin
          cmd.op     = DP_FIT_BEGIN;
          state_next = (stat.mode == MODE_CLOSED) ? ST_DEN0 : ST_GD_INIT;
        end
      end
      ST_FIN: begin
        cmd.op     = DP_FIN;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = DP_PUSH;
          state_next = ST_IDLE;
        end
      end
      // closed form: denominator n*sxx - sx*sx
      ST_DEN0:  begin cmd.op = DP_MUL_NSXX; state_next = ST_DEN0W; end
      ST_DEN0W: if (stat.mul_done) begin cmd.op = DP_DEN_SET; state_next = ST_DEN1; end
      ST_DEN1:  begin cmd.op = DP_MUL_SXSX; state_next = ST_DEN1W; end
      ST_DEN1W: if (stat.mul_done) begin cmd.op = DP_DEN_SUB; state_next = ST_DENCHK; end
      ST_DENCHK: begin
        if (stat.den_bad) begin
          cmd.op     = DP_DEGEN;
          state_next = ST_FIN;
        end else begin
          state_next = ST_NW0;
        end
      end
      ST_NW0:  begin cmd.op = DP_MUL_NSXY; state_next = ST_NW0W; end
      ST_NW0W: if (stat.mul_done) begin cmd.op = DP_NUM_SET; state_next = ST_NW1; end
      ST_NW1:  begin cmd.op = DP_MUL_SXSY; state_next = ST_NW1W; end
      ST_NW1W: if (stat.mul_done) begin cmd.op = DP_NUM_SUB; state_next = ST_DW; end
      ST_DW:   begin cmd.op = DP_DIV_W; state_next = ST_DWW; end
      ST_DWW:  if (stat.div_done) begin cmd.op = DP_W_FROM_Q; state_next = ST_NB0; end
      ST_NB0:  begin cmd.op = DP_MUL_SXXSY; state_next = ST_NB0W; end
      ST_NB0W: if (stat.mul_done) begin cmd.op = DP_NUM_SET; state_next = ST_NB1; end
      ST_NB1:  begin cmd.op = DP_MUL_SXSXY; state_next = ST_NB1W; end
      ST_NB1W: if (stat.mul_done) begin cmd.op = DP_NUM_SUB; state_next = ST_DB; end
      ST_DB:   begin cmd.op = DP_DIV_B; state_next = ST_DBW; end
      ST_DBW:  if (stat.div_done) begin cmd.op = DP_B_FROM_Q; state_next = ST_FIN; end
      // gradient descent
      ST_GD_INIT: begin
        cmd.op     = DP_GD_INIT;
        state_next = stat.pass_zero ? ST_GD_END : ST_PASS;
      end
      ST_PASS:   begin cmd.op = DP_PASS_BEGIN; state_next = ST_PT_RD; end
      ST_PT_RD:  state_next = ST_PT_M1;
      ST_PT_M1:  begin cmd.op = DP_PT_MUL1; state_next = ST_PT_ERR; end
      ST_PT_ERR: begin cmd.op = DP_PT_ERR;  state_next = ST_PT_M2; end
      ST_PT_M2:  begin cmd.op = DP_PT_MUL2; state_next = ST_PT_ACC; end
      ST_PT_ACC: begin
        cmd.op     = DP_PT_ACC;
        state_next = stat.idx_last ? ST_DSE : ST_PT_RD;
      end
      ST_DSE:  begin cmd.op = DP_DIV_SE; state_next = ST_DSEW; end
      ST_DSEW: if (stat.div_done) begin cmd.op = DP_SE_FROM_Q; state_next = ST_DSX; end
      ST_DSX:  begin cmd.op = DP_DIV_SEX; state_next = ST_DSXW; end
      ST_DSXW: if (stat.div_done) begin cmd.op = DP_SEX_FROM_Q; state_next = ST_MB; end
      ST_MB:   begin cmd.op = DP_MUL_RSE; state_next = ST_MBW; end
      ST_MBW:  if (stat.mul_done) begin cmd.op = DP_GB_UPD; state_next = ST_MW; end
      ST_MW:   begin cmd.op = DP_MUL_RSEX; state_next = ST_MWW; end
      ST_MWW: begin
        if (stat.mul_done) begin
          cmd.op     = DP_GW_UPD;
          state_next = stat.pass_last ? ST_GD_END : ST_PASS;
        end
      end
      ST_GD_END: begin cmd.op = DP_GD_END; state_next = ST_FIN; end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- src/linear_regression_fit.sv -----
// top level of the linear regression fit block
// Points (Q8.8) are taken one per cycle into a 1024-entry x/y store while the
// sums of x, y, x*x and x*y build up; a point past capacity is dropped and
// flagged. The point marked last starts the fit and the block then holds
// stall high until the result is in the output register. Closed form runs six
// products on a bit-serial 64x64 multiplier and two quotients on a bit-serial
// 80-bit divider. Gradient descent runs pass_count passes over the n stored
// points: each point goes through the store read port and the error
// multiplier, and each pass adds two divisions and two multiplications. The
// output register lets a fresh load be taken while a result waits to be
// collected.
module linear_regression_fit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lrf_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import lrf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_last  (in_data.last_point),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lrf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  // a result only moves into the output register when the slot is free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_PUSH |-> (!out_valid || !out_stall))
    else $error("result pushed over a pending one");

  // every accepted transaction is handed to the datapath
  a_accept_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cmd.op == DP_ACCEPT)
    else $error("accepted transaction not loaded");

  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_PUSH |=> out_valid)
    else $error("pushed result not presented");

endmodule
